/* design/tcw_pkg.sv */
// Package for the text console writer.
// Holds the stream field widths, request codes and cell constants; no dependencies.
package tcw_pkg;

	localparam int FUNC_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int IDX_W       = 11;
	localparam int POS_W       = 11;
	localparam int VAL_W       = 16;
	localparam int ATTR_W      = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - VAL_W;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [VAL_W-1:0]  BLANK_CELL   = 16'h0720;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

endpackage

/* design/tcw_ram.sv */
// Generic simple dual-port RAM for the text console writer.
// One write port and one read port with registered read data; no dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/text_console_writer.sv */
// A request goes from acceptance to a done state, which waits for a free output register, then
// back to idle. A line feed on the last row (put of a newline or of a character in the last
// column there) and a clear first sweep the cell memory. The screen scroll copies every cell
// below the top row one row up and then blanks the bottom row before the next request can be
// accepted. A clear blanks all ROWS*COLUMNS cells. Both work one cell per cycle through the
// single write port of the cell memory. After reset the block blanks all ROWS*COLUMNS cells
// (2000 by default) before it accepts the first request; the attribute register can be written
// at any time. A finished result waits in the output register while the next request is
// accepted, and a request whose result finds that register still full holds the input until it
// drains. Depends on tcw_pkg and tcw_ram.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // char_code, cell_index
	input  logic [tcw_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // cursor_pos, cell_value
);

	import tcw_pkg::*;

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int AW        = $clog2(CELLS);
	localparam int CW        = $clog2(COLUMNS);
	localparam int RW        = $clog2(ROWS);
	localparam int COPY_N    = CELLS - COLUMNS;
	localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DONE   = 2'd1;
	localparam logic [1:0] S_SCROLL = 2'd2;
	localparam logic [1:0] S_BLANK  = 2'd3;

	logic [1:0]        state_q;
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     pos_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [ATTR_W-1:0] attr_q;
	logic              res_pending_q;
	logic              rd_sel_q;
	logic              copy_vld_s1;
	logic [AW-1:0]     copy_addr_s1;

	logic              accept;
	logic [FUNC_W-1:0] func;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;
	logic              is_nl;
	logic              wrap;
	logic              last_row;
	logic              copy_rd;
	logic              out_free;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic [VAL_W-1:0]  res_val;

	assign func       = s_axis_tuser;
	assign char_code  = s_axis_tdata[CHAR_W-1:0];
	assign cell_index = s_axis_tdata[CHAR_W +: IDX_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_nl         = (char_code == NEWLINE_CODE);
	assign wrap          = (col_q == CW'(COLUMNS - 1));
	assign last_row      = (row_q == RW'(ROWS - 1));
	assign copy_rd       = (state_q == S_SCROLL) && (sweep_q < AW'(COPY_N));
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign res_val       = rd_sel_q ? ram_rdata : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == S_BLANK) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = BLANK_CELL;
		end else if (accept && func == FUNC_PUT && !is_nl) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = {attr_q, char_code};
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (copy_rd) begin
			ram_re    = 1'b1;
			ram_raddr = sweep_q + AW'(COLUMNS);
		end else if (accept && func == FUNC_READ) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(cell_index);
		end
	end

	tcw_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_BLANK;
			sweep_q       <= '0;
			pos_q         <= '0;
			col_q         <= '0;
			row_q         <= '0;
			res_pending_q <= 1'b0;
			rd_sel_q      <= 1'b0;
			copy_vld_s1   <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			copy_vld_s1 <= copy_rd;
			if (state_q == S_DONE && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_pending_q <= 1'b1;
						rd_sel_q      <= (func == FUNC_READ) && (32'(cell_index) < 32'(CELLS));
						state_q       <= S_DONE;
						case (func)
							FUNC_PUT: begin
								if (is_nl || wrap) begin
									col_q <= '0;
									if (last_row) begin
										pos_q   <= AW'(LAST_BASE);
										sweep_q <= '0;
										state_q <= S_SCROLL;
									end else begin
										row_q <= row_q + 1'b1;
										pos_q <= pos_q - AW'(col_q) + AW'(COLUMNS);
									end
								end else begin
									col_q <= col_q + 1'b1;
									pos_q <= pos_q + 1'b1;
								end
							end
							FUNC_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								pos_q   <= '0;
								sweep_q <= '0;
								state_q <= S_BLANK;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCROLL: begin
					if (copy_rd) begin
						sweep_q <= sweep_q + 1'b1;
					end else begin
						state_q <= S_BLANK;
					end
				end
				S_BLANK: begin
					if (sweep_q == AW'(CELLS - 1)) begin
						state_q <= res_pending_q ? S_DONE : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_pending_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= sweep_q;
		if (state_q == S_DONE && out_free) begin
			m_axis_tdata <= {{OUT_PAD_W{1'b0}}, res_val, POS_W'(pos_q)};
		end
	end

	a_blank_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BLANK) |-> !copy_vld_s1)
		else $error("copy write still pending while blanking");

	a_idle_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !copy_vld_s1)
		else $error("request accepted with a scroll copy in flight");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (32'(col_q) < 32'(COLUMNS)) && (32'(pos_q) < 32'(CELLS)))
		else $error("cursor outside the screen");

	a_done_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> m_axis_tvalid)
		else $error("finished request did not reach the output register");

endmodule

/* bench/text_console_writer_test.sv */
// Self-checking testbench for text_console_writer: drives put, clear, read and unused requests
// over the request stream, predicts every result, and checks each one. Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELL_COUNT    = COLUMNS * ROWS;
	localparam int IDX_TOP       = (1 << IDX_W) - 1;
	localparam int IN_PAD_W      = IN_TDATA_W - CHAR_W - IDX_W;
	localparam int IDLE_PERCENT  = 36;
	localparam int STALL_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int PRINT_LIMIT   = 40;
	localparam longint CYCLE_LIMIT = 2_000_000;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} console_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [ATTR_W-1:0]      cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // char_code, cell_index
	logic [FUNC_W-1:0]      s_axis_tuser = '0;   // func
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // cursor_pos, cell_value

	logic [VAL_W-1:0]  screen_model [CELL_COUNT];
	int                cur_col;
	int                cur_row;
	logic [ATTR_W-1:0] attr_model;
	console_reply_t    console_replies [$];

	int     request_count;
	int     read_count;
	int     scroll_count;
	int     clear_count;
	int     mismatch_count;
	bit     idle_on = 1'b1;
	int     hold_asked;
	int     hold_served;
	int     hold_left;
	longint cycle_count;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
				console_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("Mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
	endtask

	function automatic int cursor_index();
		return cur_row * COLUMNS + cur_col;
	endfunction

	task automatic blank_screen_model();
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = BLANK_CELL;
	endtask

	task automatic advance_line();
		cur_col = 0;
		if (cur_row >= ROWS - 1) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				screen_model[i] = screen_model[i + COLUMNS];
			for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
				screen_model[i] = BLANK_CELL;
			scroll_count++;
		end else begin
			cur_row++;
		end
	endtask

	task automatic apply_console_request(input logic [FUNC_W-1:0] func,
			input logic [CHAR_W-1:0] char_code, input logic [IDX_W-1:0] cell_index);
		console_reply_t reply;
		reply.value = '0;
		case (func)
			FUNC_PUT: begin
				if (char_code == NEWLINE_CODE) begin
					advance_line();
				end else begin
					screen_model[cursor_index()] = {attr_model, char_code};
					cur_col++;
					if (cur_col >= COLUMNS)
						advance_line();
				end
			end
			FUNC_CLEAR: begin
				blank_screen_model();
				cur_col = 0;
				cur_row = 0;
				clear_count++;
			end
			FUNC_READ: begin
				read_count++;
				if (cell_index < CELL_COUNT)
					reply.value = screen_model[cell_index];
			end
			default: begin
			end
		endcase
		reply.pos = POS_W'(cursor_index());
		console_replies.push_back(reply);
		request_count++;
	endtask

	always @(posedge clk) begin : result_check
		console_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (console_replies.size() == 0) begin
				report_mismatch("unexpected result", longint'(m_axis_tdata), 0);
			end else begin
				want = console_replies.pop_front();
				if (m_axis_tdata[POS_W-1:0] !== want.pos)
					report_mismatch("cursor_pos", longint'(m_axis_tdata[POS_W-1:0]),
						longint'(want.pos));
				if (m_axis_tdata[POS_W +: VAL_W] !== want.value)
					report_mismatch("cell_value", longint'(m_axis_tdata[POS_W +: VAL_W]),
						longint'(want.value));
			end
		end
	end

	// The receiver idles at random, and holds off for a long stretch whenever a test asks.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = STALL_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] char_code,
			input logic [IDX_W-1:0] cell_index);
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {{IN_PAD_W{1'b0}}, cell_index, char_code};
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_console_request(func, char_code, cell_index);
	endtask

	task automatic drain_console();
		s_axis_tvalid <= 1'b0;
		while (console_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_attr(input logic [ATTR_W-1:0] attr);
		cfg_we <= 1'b1;
		cfg_wdata <= attr;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr_model = attr;
	endtask

	function automatic logic [CHAR_W-1:0] random_glyph();
		logic [CHAR_W-1:0] glyph;
		glyph = CHAR_W'($urandom_range(0, 255));
		if (glyph == NEWLINE_CODE)
			glyph = glyph ^ 8'h80;
		return glyph;
	endfunction

	function automatic logic [IDX_W-1:0] pick_read_index();
		int r;
		int base;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			base = cursor_index() - int'($urandom_range(0, 2 * COLUMNS));
			return (base < 0) ? '0 : IDX_W'(base);
		end else if (r < 85) begin
			return IDX_W'($urandom_range(0, IDX_TOP));
		end
		return IDX_W'($urandom_range(CELL_COUNT - 100, IDX_TOP));
	endfunction

	task automatic send_random_request(input int clear_percent);
		int r;
		logic [CHAR_W-1:0] glyph;
		r = $urandom_range(0, 99);
		glyph = CHAR_W'($urandom_range(0, 255));
		if (r < 60)
			send_request(FUNC_PUT, ($urandom_range(0, 99) < 8) ? NEWLINE_CODE : glyph,
				IDX_W'($urandom));
		else if (r < 88)
			send_request(FUNC_READ, glyph, pick_read_index());
		else if (r < 88 + clear_percent)
			send_request(FUNC_CLEAR, glyph, IDX_W'($urandom));
		else
			send_request(FUNC_UNUSED, glyph, IDX_W'($urandom));
	endtask

	// Field extremes, every request kind, out-of-range reads and both attribute extremes.
	task automatic test_edge_requests();
		write_attr(8'hFF);
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'hFF, 11'(CELL_COUNT - 1));
		send_request(FUNC_READ, 8'h00, 11'(CELL_COUNT));
		send_request(FUNC_READ, 8'hFF, 11'(IDX_TOP));
		send_request(FUNC_PUT, 8'h00, 11'(IDX_TOP));
		send_request(FUNC_PUT, 8'hFF, 11'd0);
		send_request(FUNC_PUT, 8'h55, 11'h2AA);
		send_request(FUNC_PUT, 8'hAA, 11'h555);
		send_request(FUNC_UNUSED, 8'hFF, 11'(IDX_TOP));
		send_request(FUNC_PUT, NEWLINE_CODE, 11'd3);
		for (int i = 0; i < 5; i++)
			send_request(FUNC_READ, 8'h0A, 11'(i));
		send_request(FUNC_PUT, 8'h41, 11'd0);
		drain_console();
		write_attr(8'h00);
		send_request(FUNC_PUT, 8'h7E, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'(COLUMNS + 1));
		send_request(FUNC_CLEAR, 8'hFF, 11'(IDX_TOP));
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'(COLUMNS));
		drain_console();
	endtask

	// Lines of random text fill the screen, wrap at the last column and scroll at the bottom.
	task automatic test_wrap_and_scroll();
		int r;
		int line_len;
		for (int pass_n = 0; pass_n < 2; pass_n++) begin
			write_attr(ATTR_W'($urandom_range(0, 255)));
			send_request(FUNC_CLEAR, random_glyph(), IDX_W'($urandom));
			for (int row_n = 0; row_n < 30; row_n++) begin
				r = $urandom_range(0, 99);
				if (row_n == 29 || (r >= 92 && r < 96))
					line_len = COLUMNS;
				else if (r < 70)
					line_len = $urandom_range(0, 5);
				else if (r < 92)
					line_len = $urandom_range(6, 15);
				else
					line_len = $urandom_range(0, 1) ? COLUMNS - 1 : COLUMNS + 1;
				for (int k = 0; k < line_len; k++)
					send_request(FUNC_PUT, random_glyph(), IDX_W'($urandom));
				if (line_len != COLUMNS || $urandom_range(0, 1))
					send_request(FUNC_PUT, NEWLINE_CODE, IDX_W'($urandom));
				repeat ($urandom_range(0, 2))
					send_request(FUNC_READ, random_glyph(), pick_read_index());
			end
			drain_console();
		end
	endtask

	task automatic test_random_traffic();
		write_attr(ATTR_W'($urandom_range(0, 255)));
		repeat (300)
			send_random_request(3);
		drain_console();
	endtask

	task automatic test_back_to_back();
		write_attr(8'h07);
		idle_on = 1'b0;
		repeat (100)
			send_random_request(1);
		drain_console();
	endtask

	// The receiver holds off while requests keep coming, so the block must stall its input.
	task automatic test_output_stall();
		write_attr(8'hFF);
		idle_on = 1'b0;
		hold_asked++;
		repeat (40)
			send_random_request(0);
		drain_console();
		idle_on = 1'b1;
	endtask

	initial begin
		blank_screen_model();
		cur_col = 0;
		cur_row = 0;
		attr_model = ATTR_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_requests();
		test_wrap_and_scroll();
		test_random_traffic();
		test_back_to_back();
		test_output_stall();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (console_replies.size() != 0)
			report_mismatch("results never delivered", longint'(console_replies.size()), 0);
		$display("Run covered %0d requests: %0d reads, %0d scrolls, %0d clears.",
			request_count, read_count, scroll_count, clear_count);
		$display("Attributes ranged over both extremes, with random gaps and one long output stall.");
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
